[rtl/sliding_window_median_defines.svh]
// Assertion macros shared by the sliding window median RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef SLIDING_WINDOW_MEDIAN_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_DEFINES_SVH

// Property holds at every rising clock edge outside reset.
`define SWM_ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("sliding_window_median: check failed");

// Same-cycle implication.
`define SWM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sliding_window_median: check failed");

// Next-cycle implication.
`define SWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sliding_window_median: check failed");

`endif

[rtl/swm_pkg.sv]
// Shared types and constants for the sliding window median.
// No dependencies; imported by the cell and the top level.
package swm_pkg;

   localparam int CFG_LEN_BITS  = 7;
   localparam int LEN_RESET     = 3;
   localparam int APB_DATA_BITS = 32;
   localparam int APB_ADDR_BITS = 3;

   // Register select: paddr[2] (word address), register 0 is window_len
   localparam logic REG_WINDOW_LEN = 1'b0;

   // Broadcast to every cell for one request
   typedef struct packed {
      logic load;     // request accepted, cells take their next value
      logic remove;   // window full, oldest sample leaves
   } swm_step_type;

   // Compare flags a cell hands to its neighbors
   typedef struct packed {
      logic gt_new;   // cell is above the new sample (or empty)
      logic ge_old;   // cell sits at or above the leaving sample's slot
   } swm_flag_type;

endpackage

[rtl/sliding_window_median.sv]
// Sliding window median over a stream of signed samples.
// Depends on swm_pkg, swm_cell, swm_arrival_ring, swm_median_pick and
// sliding_window_median_defines.svh.
//
// Usage:
//  - req channel: one sample per request, req_restart empties the window
//    before the sample is taken.
//  - rsp channel: one median per request once the window holds window_len
//    samples; requests that only fill the window give no response.
//  - APB register 0 (byte address 0): window_len, 7 bits, reset 3.
//    0 acts as 1, values above WINDOW_MAX act as WINDOW_MAX. A write
//    empties the window. Write it only while the block is idle.
//  - Pipeline: the chain updates at the edge that accepts a request; the
//    middle-cell pick register and the averaging register follow, and the
//    response then shows on rsp_valid.
//  - Throughput: 1 request per cycle while req_stall is low; the whole
//    sorted chain takes one removal and one insertion at the accepting edge,
//    each cell choosing from itself or a neighbor.
//  - When the receiver stalls a waiting response, the pick stages hold
//    and req_stall rises, so nothing is lost or repeated.
//  - Reset: window empty, window_len = 3, no response pending. The sample
//    stores have no reset; only slots written since are ever read.
`include "sliding_window_median_defines.svh"

module sliding_window_median import swm_pkg::*; #(
   parameter int WINDOW_MAX  = 64,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_restart,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_median,
   // register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [APB_ADDR_BITS-1:0]      paddr,
   input  logic [APB_DATA_BITS-1:0]      pwdata,
   output logic [APB_DATA_BITS-1:0]      prdata,
   output logic                          pready
);

   localparam int LEN_W     = $clog2(WINDOW_MAX + 1);
   localparam int POS_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CMP_W     = (LEN_W > CFG_LEN_BITS) ? LEN_W : CFG_LEN_BITS;
   localparam int LEN_RST_E = (LEN_RESET > WINDOW_MAX) ? WINDOW_MAX : LEN_RESET;

   // ---------------------------------------------------------------
   // Register port
   // ---------------------------------------------------------------
   logic [CFG_LEN_BITS-1:0] cfg_len_ff, cfg_len_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [CMP_W-1:0]        cfg_wide;
   logic                    cfg_wr_len;

   assign pready     = 1'b1;
   assign cfg_wr_len = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_LEN);

   always_comb begin
      cfg_len_in = cfg_len_ff;
      len_in     = len_ff;
      cfg_wide   = CMP_W'(pwdata[CFG_LEN_BITS-1:0]);
      if (cfg_wr_len) begin
         cfg_len_in = pwdata[CFG_LEN_BITS-1:0];
         // zero means one, oversize means the chain length
         if (cfg_wide == '0) begin
            len_in = LEN_W'(1);
         end else if (cfg_wide > CMP_W'(WINDOW_MAX)) begin
            len_in = LEN_W'(WINDOW_MAX);
         end else begin
            len_in = LEN_W'(cfg_wide);
         end
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_WINDOW_LEN: prdata = APB_DATA_BITS'(cfg_len_ff);
         default:        prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Window bookkeeping for the request being taken
   // ---------------------------------------------------------------
   logic [LEN_W-1:0]              fill_ff, fill_in, fill_eff, fill_next;
   logic [POS_W-1:0]              ring_pos_ff, ring_pos_in, pos_base, pos_eff, pos_next;
   logic [LEN_W-1:0]              pos_inc;
   logic                          s1_valid_ff, s1_valid_in;
   logic                          accept, advance, remove, full_after;
   logic signed [SAMPLE_BITS-1:0] old_sample;
   swm_step_type                  step;

   assign req_stall = !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      fill_eff   = req_restart ? '0 : fill_ff;
      pos_base   = req_restart ? '0 : ring_pos_ff;
      pos_eff    = (LEN_W'(pos_base) >= len_ff) ? '0 : pos_base;
      remove     = (fill_eff >= len_ff);
      fill_next  = remove ? fill_eff : fill_eff + 1'b1;
      full_after = (fill_next >= len_ff);
      pos_inc    = LEN_W'(pos_eff) + 1'b1;
      pos_next   = (pos_inc >= len_ff) ? '0 : POS_W'(pos_inc);
   end

   always_comb begin
      fill_in     = fill_ff;
      ring_pos_in = ring_pos_ff;
      s1_valid_in = s1_valid_ff;
      if (cfg_wr_len) begin
         fill_in     = '0;
         ring_pos_in = '0;
      end else if (accept) begin
         fill_in     = fill_next;
         ring_pos_in = pos_next;
      end
      // chain result handed to the pick stage
      if (advance) begin
         s1_valid_in = accept && full_after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_len_ff  <= CFG_LEN_BITS'(LEN_RESET);
         len_ff      <= LEN_W'(LEN_RST_E);
         fill_ff     <= '0;
         ring_pos_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         cfg_len_ff  <= cfg_len_in;
         len_ff      <= len_in;
         fill_ff     <= fill_in;
         ring_pos_ff <= ring_pos_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Ring is read one request ahead: the slot about to be overwritten
   // is already on rd_data when its request arrives.
   swm_arrival_ring #(
      .DEPTH  (WINDOW_MAX),
      .ADDR_W (POS_W),
      .DATA_W (SAMPLE_BITS)
   ) u_ring (
      .clock     (clock),
      .wr_en_i   (accept),
      .wr_addr_i (pos_eff),
      .wr_data_i (req_sample),
      .rd_addr_i (ring_pos_in),
      .rd_data_o (old_sample)
   );

   // ---------------------------------------------------------------
   // Sorted chain
   // ---------------------------------------------------------------
   logic signed [SAMPLE_BITS-1:0] cell_val [WINDOW_MAX];
   swm_flag_type                  cell_flag [WINDOW_MAX];
   logic signed [SAMPLE_BITS-1:0] lo_val [WINDOW_MAX];
   logic signed [SAMPLE_BITS-1:0] hi_val [WINDOW_MAX];
   swm_flag_type                  lo_flag [WINDOW_MAX];
   swm_flag_type                  hi_flag [WINDOW_MAX];
   logic [WINDOW_MAX-1:0]         cell_vld;
   logic [WINDOW_MAX-1:0]         order_ok;

   assign step.load   = accept;
   assign step.remove = remove;

   for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
      assign cell_vld[k] = (LEN_W'(k) < fill_eff);

      // chain ends: below the first cell is -inf, above the last +inf
      if (k == 0) begin : g_lo_end
         assign lo_val[k]  = '0;
         assign lo_flag[k] = '{gt_new: 1'b0, ge_old: 1'b0};
      end else begin : g_lo
         assign lo_val[k]  = cell_val[k-1];
         assign lo_flag[k] = cell_flag[k-1];
      end
      if (k == WINDOW_MAX - 1) begin : g_hi_end
         assign hi_val[k]  = '0;
         assign hi_flag[k] = '{gt_new: 1'b1, ge_old: 1'b1};
         assign order_ok[k] = 1'b1;
      end else begin : g_hi
         assign hi_val[k]  = cell_val[k+1];
         assign hi_flag[k] = cell_flag[k+1];
         assign order_ok[k] = (LEN_W'(k + 1) >= fill_ff) || (cell_val[k] <= cell_val[k+1]);
      end

      swm_cell #(
         .DATA_W (SAMPLE_BITS)
      ) u_cell (
         .clock     (clock),
         .vld_i     (cell_vld[k]),
         .step_i    (step),
         .sample_i  (req_sample),
         .old_i     (old_sample),
         .lo_val_i  (lo_val[k]),
         .lo_flag_i (lo_flag[k]),
         .hi_val_i  (hi_val[k]),
         .hi_flag_i (hi_flag[k]),
         .val_o     (cell_val[k]),
         .flag_o    (cell_flag[k])
      );
   end

   // ---------------------------------------------------------------
   // Median pick and output register
   // ---------------------------------------------------------------
   swm_median_pick #(
      .N      (WINDOW_MAX),
      .DATA_W (SAMPLE_BITS),
      .LEN_W  (LEN_W)
   ) u_pick (
      .clock        (clock),
      .reset        (reset),
      .cells_i      (cell_val),
      .len_i        (len_ff),
      .s1_valid_i   (s1_valid_ff),
      .rsp_stall_i  (rsp_stall),
      .advance_o    (advance),
      .rsp_valid_o  (rsp_valid),
      .rsp_median_o (rsp_median)
   );

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   `SWM_ASSERT_ALWAYS(a_fill_within_len, clock, reset, fill_ff <= len_ff)
   `SWM_ASSERT_IMPLY(a_pos_tracks_fill, clock, reset, fill_ff < len_ff, LEN_W'(ring_pos_ff) == fill_ff)
   `SWM_ASSERT_ALWAYS(a_chain_sorted, clock, reset, &order_ok)
   `SWM_ASSERT_IMPLY(a_result_only_full, clock, reset, s1_valid_ff, fill_ff == len_ff)

endmodule

[rtl/swm_cell.sv]
// One slot of the sorted chain: holds a sample, compares it with the
// broadcast values and picks its next value from itself or a neighbor.
// Depends on swm_pkg.
module swm_cell import swm_pkg::*; #(
   parameter int DATA_W = 32
) (
   input  logic                     clock,
   input  logic                     vld_i,
   input  swm_step_type             step_i,
   input  logic signed [DATA_W-1:0] sample_i,
   input  logic signed [DATA_W-1:0] old_i,
   input  logic signed [DATA_W-1:0] lo_val_i,
   input  swm_flag_type             lo_flag_i,
   input  logic signed [DATA_W-1:0] hi_val_i,
   input  swm_flag_type             hi_flag_i,
   output logic signed [DATA_W-1:0] val_o,
   output swm_flag_type             flag_o
);

   logic signed [DATA_W-1:0] val_ff, val_in;
   logic signed [DATA_W-1:0] cur_val, prv_val;
   logic                     cur_gt, prv_gt;

   // empty cells act as +infinity
   assign flag_o.gt_new = !vld_i || (val_ff > sample_i);
   assign flag_o.ge_old = step_i.remove && (!vld_i || (val_ff >= old_i));
   assign val_o         = val_ff;

   always_comb begin
      // list after removal, at this slot and the one below
      if (flag_o.ge_old) begin
         cur_val = hi_val_i;
         cur_gt  = hi_flag_i.gt_new;
      end else begin
         cur_val = val_ff;
         cur_gt  = flag_o.gt_new;
      end
      if (lo_flag_i.ge_old) begin
         prv_val = val_ff;
         prv_gt  = flag_o.gt_new;
      end else begin
         prv_val = lo_val_i;
         prv_gt  = lo_flag_i.gt_new;
      end
      // insert after equal values
      if (prv_gt) begin
         val_in = prv_val;
      end else if (cur_gt) begin
         val_in = sample_i;
      end else begin
         val_in = cur_val;
      end
   end

   always_ff @(posedge clock) begin
      if (step_i.load) begin
         val_ff <= val_in;
      end
   end

endmodule

[rtl/swm_arrival_ring.sv]
// Arrival-order store: one write port, one registered read port with
// write-through when both hit the same slot. No dependencies.
module swm_arrival_ring #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6,
   parameter int DATA_W = 32
) (
   input  logic                     clock,
   input  logic                     wr_en_i,
   input  logic [ADDR_W-1:0]        wr_addr_i,
   input  logic signed [DATA_W-1:0] wr_data_i,
   input  logic [ADDR_W-1:0]        rd_addr_i,
   output logic signed [DATA_W-1:0] rd_data_o
);

   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en_i) begin
         mem[wr_addr_i] <= wr_data_i;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
         rd_data_ff <= wr_data_i;
      end else begin
         rd_data_ff <= mem[rd_addr_i];
      end
   end

   assign rd_data_o = rd_data_ff;

endmodule

[rtl/swm_median_pick.sv]
// Picks the middle cell(s) of the chain and forms the median; two
// registered stages that hold while the receiver stalls. No dependencies.
module swm_median_pick #(
   parameter int N      = 64,
   parameter int DATA_W = 32,
   parameter int LEN_W  = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [DATA_W-1:0] cells_i [N],
   input  logic [LEN_W-1:0]         len_i,
   input  logic                     s1_valid_i,
   input  logic                     rsp_stall_i,
   output logic                     advance_o,
   output logic                     rsp_valid_o,
   output logic signed [DATA_W-1:0] rsp_median_o
);

   logic [LEN_W-1:0]         mid;
   logic signed [DATA_W-1:0] lo_pick, hi_pick;
   logic signed [DATA_W-1:0] lo_ff, hi_ff, median_ff, median_in;
   logic                     odd_ff, v1_ff, out_valid_ff;
   logic signed [DATA_W:0]   pair_sum, pair_adj;

   assign mid       = len_i >> 1;
   assign advance_o = !(out_valid_ff && rsp_stall_i);

   always_comb begin
      lo_pick = '0;
      hi_pick = '0;
      for (int k = 0; k < N; k++) begin
         if (LEN_W'(k) == mid) begin
            hi_pick = hi_pick | cells_i[k];
         end
         if (LEN_W'(k + 1) == mid) begin
            lo_pick = lo_pick | cells_i[k];
         end
      end
   end

   // even window: halve the wide sum, rounding toward zero
   always_comb begin
      pair_sum = {lo_ff[DATA_W-1], lo_ff} + {hi_ff[DATA_W-1], hi_ff};
      pair_adj = pair_sum + {{DATA_W{1'b0}}, pair_sum[DATA_W]};
      if (odd_ff) begin
         median_in = hi_ff;
      end else begin
         median_in = pair_adj[DATA_W:1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance_o) begin
         v1_ff        <= s1_valid_i;
         out_valid_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance_o) begin
         lo_ff     <= lo_pick;
         hi_ff     <= hi_pick;
         odd_ff    <= len_i[0];
         median_ff <= median_in;
      end
   end

   assign rsp_valid_o  = out_valid_ff;
   assign rsp_median_o = median_ff;

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for sliding_window_median: predicts every running median
// and checks the response stream under random request and response flow control.
// Depends on swm_pkg and the sliding_window_median RTL.
module tb_top import swm_pkg::*; ();

   localparam int WIN_MAX     = 64;
   localparam int SMP_BITS    = 32;
   localparam int SETTLE      = 8;        // settle wait after every median is out
   localparam int CYCLE_LIMIT = 200000;
   localparam int NUM_PHASES  = 8;

   // window_len sits at word 0; the next word holds no register
   localparam logic [APB_ADDR_BITS-1:0] LEN_ADDR   = {REG_WINDOW_LEN, 2'b00};
   localparam logic [APB_ADDR_BITS-1:0] SPARE_ADDR = {~REG_WINDOW_LEN, 2'b00};

   typedef logic signed [SMP_BITS-1:0] sample_type;
   typedef struct {
      sample_type sample;
      logic       restart;
   } sample_req_type;

   localparam sample_type S_MIN = {1'b1, {(SMP_BITS-1){1'b0}}};
   localparam sample_type S_MAX = {1'b0, {(SMP_BITS-1){1'b1}}};

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_stall;
   sample_type               req_sample  = '0;
   logic                     req_restart = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall   = 1'b0;
   sample_type               rsp_median;
   logic                     psel        = 1'b0;
   logic                     penable     = 1'b0;
   logic                     pwrite      = 1'b0;
   logic [APB_ADDR_BITS-1:0] paddr       = '0;
   logic [APB_DATA_BITS-1:0] pwdata      = '0;
   logic [APB_DATA_BITS-1:0] prdata;
   logic                     pready;

   sample_req_type pending_reqs [$];       // requests not yet put on the bus
   sample_type     expected_medians [$];   // medians predicted, not yet seen
   int             send_idle_pct  = 0;
   int             recv_stall_pct = 0;
   int             errors = 0;
   int             cycles = 0;

   // Shadow of the block: register, arrival ring, sorted window contents
   logic [CFG_LEN_BITS-1:0] win_len_reg = CFG_LEN_BITS'(LEN_RESET);
   sample_type              arrivals [WIN_MAX];
   sample_type              sorted_win [$];
   int                      oldest_slot = 0;

   sliding_window_median #(
      .WINDOW_MAX (WIN_MAX),
      .SAMPLE_BITS(SMP_BITS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .req_restart(req_restart),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_median (rsp_median),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Length the window really uses: 0 behaves as 1, oversize clamps to the max
   function automatic int active_len();
      if (win_len_reg == 0) return 1;
      if (win_len_reg > WIN_MAX) return WIN_MAX;
      return win_len_reg;
   endfunction

   function automatic void clear_window();
      sorted_win.delete();
      oldest_slot = 0;
   endfunction

   // Slide one sample into the window. Returns 1 with the median once full.
   function automatic bit slide_window(input sample_type s, input logic restart,
                                       output sample_type med);
      int     len;
      int     pos;
      longint pair_sum;
      len = active_len();
      pos = 0;
      med = '0;
      if (restart) clear_window();
      if (oldest_slot >= len) oldest_slot = 0;
      // full window: drop one copy of the oldest value
      if (sorted_win.size() >= len) begin
         while (sorted_win[pos] != arrivals[oldest_slot]) pos++;
         sorted_win.delete(pos);
      end
      arrivals[oldest_slot] = s;
      pos = 0;
      while (pos < sorted_win.size() && sorted_win[pos] <= s) pos++;
      sorted_win.insert(pos, s);
      oldest_slot = (oldest_slot + 1 >= len) ? 0 : oldest_slot + 1;
      if (sorted_win.size() < len) return 0;
      if (len % 2) begin
         med = sorted_win[len / 2];
      end else begin
         // 64-bit sum, so the extremes cannot wrap; / truncates toward zero
         pair_sum = longint'(sorted_win[len / 2 - 1]) + longint'(sorted_win[len / 2]);
         med = sample_type'(pair_sum / 2);
      end
      return 1;
   endfunction

   function automatic void queue_req(input sample_type s, input logic restart);
      pending_reqs.push_back('{s, restart});
   endfunction

   // Mix of corner values, a narrow band that forces duplicates, and full range
   function automatic sample_type pick_sample();
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(5))
               0: return S_MIN;
               1: return S_MAX;
               2: return S_MIN + 1;
               3: return S_MAX - 1;
               4: return -1;
               default: return 0;
            endcase
         end
         1, 2, 3: return sample_type'($urandom_range(16)) - 8;
         default: return $urandom;
      endcase
   endfunction

   // APB write: setup, then access; lands at the edge with pready high.
   // Upper data bits are random; only the low bits belong to the register.
   task automatic write_reg(input logic [APB_ADDR_BITS-1:0] addr,
                            input logic [CFG_LEN_BITS-1:0] len);
      logic [APB_DATA_BITS-1:0] data;
      data = $urandom;
      data[CFG_LEN_BITS-1:0] = len;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      // only window_len exists; it also empties the window
      if (addr == LEN_ADDR) begin
         win_len_reg = len;
         clear_window();
      end
   endtask

   // Wait until every request is in and every median is out. Checked on the
   // falling edge so the driver and monitor updates of the rising edge are done.
   task automatic wait_idle(input int settle);
      do @(negedge clock);
      while (pending_reqs.size() > 0 || req_valid || expected_medians.size() > 0);
      repeat (settle) @(posedge clock);
   endtask

   // Request driver: predict on acceptance, then offer the next request
   // unless the random gap says idle. A stalled request is held as is.
   always @(posedge clock) begin
      sample_type med;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (slide_window(req_sample, req_restart, med)) expected_medians.push_back(med);
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid   <= 1'b1;
               req_sample  <= pending_reqs[0].sample;
               req_restart <= pending_reqs[0].restart;
               void'(pending_reqs.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor with random back-pressure
   always @(posedge clock) begin
      sample_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_medians.size() == 0) begin
               $display("%0t: median expected none, got %0d", $time, rsp_median);
               errors++;
            end else begin
               want = expected_medians.pop_front();
               if (rsp_median !== want) begin
                  $display("%0t: median expected %0d, got %0d", $time, want, rsp_median);
                  errors++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int   ph;
      int   len;
      int   left;
      int   n;
      int   chunk_no;
      bit   noisy;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset length of 3: extremes, restart, a run of equal values
      queue_req(S_MIN, 1'b0);
      queue_req(S_MAX, 1'b0);
      queue_req(0, 1'b0);
      queue_req(-1, 1'b0);
      queue_req(5, 1'b1);
      queue_req(5, 1'b0);
      queue_req(5, 1'b0);
      queue_req(5, 1'b0);
      queue_req(S_MIN, 1'b0);
      wait_idle(SETTLE);

      // Even length: sum of the extremes, negative halves truncate toward zero
      write_reg(LEN_ADDR, CFG_LEN_BITS'(2));
      queue_req(S_MAX, 1'b0);
      queue_req(S_MAX, 1'b0);
      queue_req(S_MIN, 1'b0);
      queue_req(S_MIN, 1'b0);
      queue_req(-3, 1'b0);
      queue_req(0, 1'b0);
      queue_req(3, 1'b0);
      wait_idle(SETTLE);

      // Write to the empty register slot must leave the window intact
      write_reg(SPARE_ADDR, CFG_LEN_BITS'($urandom));
      queue_req(-4, 1'b0);
      queue_req(-5, 1'b0);
      wait_idle(SETTLE);

      // Length 1 with restart: median on the very request
      write_reg(LEN_ADDR, CFG_LEN_BITS'(1));
      queue_req(7, 1'b1);
      queue_req(S_MIN, 1'b0);
      wait_idle(SETTLE);

      // Random phases: zero and oversize lengths, full length, even, length 3 and
      // random lengths, each phase setting an idle/stall mix
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: begin len = 0;       send_idle_pct <= 0;  recv_stall_pct <= 0;  left = 120; end
            1: begin len = WIN_MAX; send_idle_pct <= 86; recv_stall_pct <= 0;  left = 260; end
            2: begin len = 127;     send_idle_pct <= 0;  recv_stall_pct <= 86; left = 200; end
            3: begin len = 2;       send_idle_pct <= 16; recv_stall_pct <= 16; left = 150; end
            7: begin len = 3;       send_idle_pct <= 16; recv_stall_pct <= 16; left = 180; end
            default: begin
               len  = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(1, 9);
               send_idle_pct  <= (ph == 5) ? 86 : 0;
               recv_stall_pct <= (ph == 6) ? 86 : 0;
               left = 180;
            end
         endcase
         write_reg(LEN_ADDR, CFG_LEN_BITS'(len));
         if ($urandom_range(1)) write_reg(SPARE_ADDR, CFG_LEN_BITS'($urandom));
         chunk_no = 0;
         while (left > 0) begin
            n = $urandom_range(20, 60);
            if (n > left) n = left;
            // most chunks restart rarely so the window fills; a few are
            // restart-heavy and break the sequence up
            noisy = ($urandom_range(9) == 0);
            repeat (n) begin
               queue_req(pick_sample(), noisy ? ($urandom_range(2) == 0)
                                              : ($urandom_range(8 * active_len() + 16) == 0));
            end
            left -= n;
            chunk_no++;
            // sender holds off until the pipeline has drained
            if (chunk_no == 1 || $urandom_range(3) == 0) wait_idle(0);
         end
         wait_idle(SETTLE);
      end

      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
